/* rtl/utf8_to_ucs2_decoder_assert.svh */
// assertion macros shared by the decoder rtl
// expects signals clk and rst in the scope of each use
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// same-cycle implication
`define U8DEC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8dec assertion failed");

// next-cycle implication
`define U8DEC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8dec assertion failed");

`endif

/* rtl/u8dec_pkg.sv */
// shared types and constants for the utf-8 to ucs-2 decoder
// no dependencies
package u8dec_pkg;

  localparam int unsigned MAX_CAPACITY = 4096;
  localparam int unsigned CAP_W        = 13;
  localparam int unsigned CNT_W        = 12;
  localparam int unsigned CHAR_W       = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(MAX_CAPACITY);

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_CODE  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_CODE  = 8'hE0;
  localparam logic [7:0] BYTE_NUL    = 8'h00;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one queued command: up to two characters, then an optional terminator
  typedef struct packed {
    logic [1:0]        nchr;
    logic [CHAR_W-1:0] ch0;
    logic [CHAR_W-1:0] ch1;
    logic              term;
    logic [CAP_W-1:0]  len;
  } cmd_t;

endpackage

/* rtl/u8dec_front.sv */
// decoder front: takes input words, tracks pending lead bytes and fill count
// depends on u8dec_pkg and utf8_to_ucs2_decoder_assert.svh
`include "utf8_to_ucs2_decoder_assert.svh"

module u8dec_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [u8dec_pkg::CAP_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 byte_value,
  input  logic                       q_full,
  output logic                       push,
  output u8dec_pkg::cmd_t            push_data
);
  import u8dec_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [7:0]       lead_byte, lead_byte_next;
  logic [7:0]       second_byte, second_byte_next;
  logic [1:0]       pending_count, pending_count_next;
  logic [CNT_W-1:0] char_count, char_count_next;

  logic [CAP_W-1:0] cap_eff;
  logic [CAP_W-1:0] cnt_p1, cnt_a_p1, cnt_b_p1;
  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic             room0, r0, r1, emit, in_fire, term_fire;
  logic [CHAR_W-1:0] ch;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;
  assign term_fire = in_fire && (byte_value == BYTE_NUL);

  assign cap_eff = (capacity > CAP_MAX) ? CAP_MAX : capacity;
  assign cnt_p1  = {1'b0, char_count} + CAP_W'(1);
  assign room0   = cnt_p1 < cap_eff;

  // terminator path: flush pending bytes as themselves while there is room
  assign r0       = (pending_count != PEND_NONE) && room0;
  assign cnt_a    = char_count + CNT_W'(r0);
  assign cnt_a_p1 = {1'b0, cnt_a} + CAP_W'(1);
  assign r1       = (pending_count == PEND_TWO) && (cnt_a_p1 < cap_eff);
  assign cnt_b    = cnt_a + CNT_W'(r1);
  assign cnt_b_p1 = {1'b0, cnt_b} + CAP_W'(1);

  always_comb begin
    lead_byte_next     = lead_byte;
    second_byte_next   = second_byte;
    pending_count_next = pending_count;
    char_count_next    = char_count;
    emit               = 1'b0;
    ch                 = {8'h00, byte_value};
    push               = 1'b0;
    push_data          = '0;
    if (in_fire) begin
      if (byte_value == BYTE_NUL) begin
        push               = 1'b1;
        push_data.nchr     = 2'(r0) + 2'(r1);
        push_data.ch0      = {8'h00, lead_byte};
        push_data.ch1      = {8'h00, second_byte};
        push_data.term     = 1'b1;
        push_data.len      = cnt_b_p1;
        pending_count_next = PEND_NONE;
        char_count_next    = '0;
      end else begin
        case (pending_count)
          PEND_NONE: begin
            if (room0) begin
              if (byte_value < ASCII_LIMIT) begin
                emit = 1'b1;
              end else if ((byte_value & LEAD2_MASK) == LEAD2_CODE ||
                           (byte_value & LEAD3_MASK) == LEAD3_CODE) begin
                lead_byte_next     = byte_value;
                pending_count_next = PEND_ONE;
              end else begin
                emit = 1'b1;
              end
            end
          end
          PEND_ONE: begin
            if ((lead_byte & LEAD2_MASK) == LEAD2_CODE) begin
              ch                 = {5'b0, lead_byte[4:0], byte_value[5:0]};
              emit               = room0;
              pending_count_next = PEND_NONE;
            end else begin
              second_byte_next   = byte_value;
              pending_count_next = PEND_TWO;
            end
          end
          default: begin
            ch                 = {lead_byte[3:0], second_byte[5:0], byte_value[5:0]};
            emit               = room0;
            pending_count_next = PEND_NONE;
          end
        endcase
        if (emit) begin
          push            = 1'b1;
          push_data.nchr  = 2'd1;
          push_data.ch0   = ch;
          char_count_next = char_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      pending_count <= PEND_NONE;
      char_count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      pending_count <= pending_count_next;
      char_count    <= char_count_next;
    end
  end

  always_ff @(posedge clk) begin
    lead_byte   <= lead_byte_next;
    second_byte <= second_byte_next;
  end

  `U8DEC_ASSERT_NEXT(a_term_clears, term_fire, char_count == '0 && pending_count == PEND_NONE)
  `U8DEC_ASSERT_IMP(a_push_needs_word, push, in_fire)
  `U8DEC_ASSERT_IMP(a_pend_range, 1'b1, pending_count <= PEND_TWO)

endmodule

/* rtl/u8dec_queue.sv */
// command queue between decoder front and output stage
// depends on u8dec_pkg and utf8_to_ucs2_decoder_assert.svh
`include "utf8_to_ucs2_decoder_assert.svh"

module u8dec_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u8dec_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output u8dec_pkg::cmd_t pop_data,
  output logic            not_empty
);
  import u8dec_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign full      = count == QCNT_W'(QDEPTH);
  assign not_empty = count != '0;
  assign pop_data  = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  `U8DEC_ASSERT_IMP(a_no_overflow, push, !full || pop)
  `U8DEC_ASSERT_IMP(a_no_underflow, pop, not_empty)
  `U8DEC_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + QCNT_W'(1))

endmodule

/* rtl/u8dec_back.sv */
// output stage: unpacks queued commands into one result word per cycle while out_ready is high
// depends on u8dec_pkg
module u8dec_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  u8dec_pkg::cmd_t              q_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u8dec_pkg::CHAR_W-1:0] code_point,
  output logic                         is_last,
  output logic [u8dec_pkg::CAP_W-1:0]  length
);
  import u8dec_pkg::*;

  cmd_t cur;
  logic busy, last_part, out_fire, done, load;

  assign last_part = (cur.nchr == 2'd0) || (cur.nchr == 2'd1 && !cur.term);
  assign out_fire  = busy && out_ready;
  assign done      = out_fire && last_part;
  assign load      = q_valid && (!busy || done);
  assign pop       = load;

  assign out_valid  = busy;
  assign is_last    = cur.nchr == 2'd0;
  assign code_point = is_last ? '0 : cur.ch0;
  assign length     = is_last ? cur.len : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end else if (out_fire && !last_part) begin
      cur.nchr <= cur.nchr - 2'd1;
      cur.ch0  <= cur.ch1;
    end
  end

endmodule

/* rtl/utf8_to_ucs2_decoder.sv */
// Decodes a zero-terminated utf-8 byte string into 16-bit characters, one
// byte word per cycle in and one character word per cycle out when nothing
// stalls. Two- and three-byte sequences are joined, other high bytes pass as
// latin-1, and the zero byte yields a terminating word with is_last set and
// the length. The front decoder takes a byte every cycle while its
// four-entry command queue has room; the output stage drains one result per
// cycle while out_ready is high, so a terminator flushing a cut-off lead
// yields up to three output words. Results are registered in the queue, then
// in the output stage. The always-ready cfg channel writes the capacity.
// depends on u8dec_pkg, u8dec_front, u8dec_queue, u8dec_back
module utf8_to_ucs2_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [u8dec_pkg::CAP_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   byte_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u8dec_pkg::CHAR_W-1:0] code_point,
  output logic                         is_last,
  output logic [u8dec_pkg::CAP_W-1:0]  length
);
  import u8dec_pkg::*;

  logic q_full, push, pop, q_valid;
  cmd_t push_data, pop_data;

  u8dec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  u8dec_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  u8dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_point (code_point),
    .is_last    (is_last),
    .length     (length)
  );

endmodule
